[hdl/amc_pkg.sv]
package amc_pkg;

  // Default sizes
  localparam int NODES_DEF     = 256;
  localparam int ALPHABET_DEF  = 256;
  localparam int MAX_DEPTH_DEF = 32;
  localparam int PATTERNS_DEF  = 256;

  // Fixed field widths and limits
  localparam int SYM_W      = 8;
  localparam int ID_W       = 8;
  localparam int POS_W      = 32;
  localparam int RESULT_CAP = 32;
  localparam int CNT_W      = $clog2(RESULT_CAP);

  typedef enum logic [1:0] {
    MODE_INSERT, MODE_BUILD, MODE_SCAN, MODE_RESTART
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK, KIND_MATCH, KIND_NOMATCH, KIND_ERROR
  } kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_INS_RD, ST_INS_DEC, ST_INS_TAG,
    ST_BLD_INIT, ST_BR_RD, ST_BR_CHK, ST_POP, ST_POP_WAIT, ST_U_LINK,
    ST_C_RD, ST_C_CHK, ST_F_RD, ST_F_CHK, ST_F_SUF, ST_T_SET, ST_BLD_DONE,
    ST_RESTART, ST_SCN_START, ST_S_RD, ST_S_CHK, ST_S_SUF, ST_S_U,
    ST_EMIT, ST_RESP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_INS_RD, OP_INS_DEC, OP_INS_TAG,
    OP_BLD_INIT, OP_BR_RD, OP_BR_CHK, OP_POP, OP_POP_WAIT, OP_U_LINK,
    OP_C_RD, OP_C_CHK, OP_F_RD, OP_F_CHK, OP_F_SUF, OP_T_SET, OP_BLD_DONE,
    OP_RESTART, OP_SCN_START, OP_S_RD, OP_S_CHK, OP_S_SUF, OP_S_U,
    OP_EMIT, OP_RESP
  } op_t;

  // Controller to datapath
  typedef struct packed {
    op_t op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  clr_last;
    mode_t mode;
    logic  ins_tag;
    logic  a_last;
    logic  q_empty;
    logic  c_zero;
    logic  f_hit;
    logic  v_hit;
    logic  u_zero;
    logic  out_free;
    logic  emit_last;
  } sts_t;

endpackage

[hdl/amc_ram.sv]
module amc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/amc_ctrl.sv]
module amc_ctrl import amc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (sts.mode)
          MODE_INSERT:  state_next = ST_INS_RD;
          MODE_BUILD:   state_next = ST_BLD_INIT;
          MODE_SCAN:    state_next = ST_SCN_START;
          MODE_RESTART: state_next = ST_RESTART;
          default:      state_next = ST_RESTART;
        endcase
      end
      ST_INS_RD:    state_next = ST_INS_DEC;
      ST_INS_DEC:   state_next = sts.ins_tag ? ST_INS_TAG : ST_RESP;
      ST_INS_TAG:   state_next = ST_RESP;
      ST_BLD_INIT:  state_next = ST_BR_RD;
      ST_BR_RD:     state_next = ST_BR_CHK;
      ST_BR_CHK:    state_next = sts.a_last ? ST_POP : ST_BR_RD;
      ST_POP:       state_next = sts.q_empty ? ST_BLD_DONE : ST_POP_WAIT;
      ST_POP_WAIT:  state_next = ST_U_LINK;
      ST_U_LINK:    state_next = ST_C_RD;
      ST_C_RD:      state_next = ST_C_CHK;
      ST_C_CHK: begin
        if (!sts.c_zero) begin
          state_next = ST_F_RD;
        end else begin
          state_next = sts.a_last ? ST_POP : ST_C_RD;
        end
      end
      ST_F_RD:      state_next = ST_F_CHK;
      ST_F_CHK:     state_next = sts.f_hit ? ST_T_SET : ST_F_SUF;
      ST_F_SUF:     state_next = ST_F_RD;
      ST_T_SET:     state_next = sts.a_last ? ST_POP : ST_C_RD;
      ST_BLD_DONE:  state_next = ST_RESP;
      ST_RESTART:   state_next = ST_RESP;
      ST_SCN_START: state_next = ST_S_RD;
      ST_S_RD:      state_next = ST_S_CHK;
      ST_S_CHK:     state_next = sts.v_hit ? ST_S_U : ST_S_SUF;
      ST_S_SUF:     state_next = ST_S_RD;
      ST_S_U:       state_next = sts.u_zero ? ST_RESP : ST_EMIT;
      ST_EMIT:      if (sts.out_free && sts.emit_last) state_next = ST_IDLE;
      ST_RESP:      if (sts.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state)
      ST_CLEAR:     cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LATCH : OP_NONE;
      end
      ST_DISPATCH:  cmd.op = OP_NONE;
      ST_INS_RD:    cmd.op = OP_INS_RD;
      ST_INS_DEC:   cmd.op = OP_INS_DEC;
      ST_INS_TAG:   cmd.op = OP_INS_TAG;
      ST_BLD_INIT:  cmd.op = OP_BLD_INIT;
      ST_BR_RD:     cmd.op = OP_BR_RD;
      ST_BR_CHK:    cmd.op = OP_BR_CHK;
      ST_POP:       cmd.op = OP_POP;
      ST_POP_WAIT:  cmd.op = OP_POP_WAIT;
      ST_U_LINK:    cmd.op = OP_U_LINK;
      ST_C_RD:      cmd.op = OP_C_RD;
      ST_C_CHK:     cmd.op = OP_C_CHK;
      ST_F_RD:      cmd.op = OP_F_RD;
      ST_F_CHK:     cmd.op = OP_F_CHK;
      ST_F_SUF:     cmd.op = OP_F_SUF;
      ST_T_SET:     cmd.op = OP_T_SET;
      ST_BLD_DONE:  cmd.op = OP_BLD_DONE;
      ST_RESTART:   cmd.op = OP_RESTART;
      ST_SCN_START: cmd.op = OP_SCN_START;
      ST_S_RD:      cmd.op = OP_S_RD;
      ST_S_CHK:     cmd.op = OP_S_CHK;
      ST_S_SUF:     cmd.op = OP_S_SUF;
      ST_S_U:       cmd.op = OP_S_U;
      ST_EMIT:      cmd.op = OP_EMIT;
      ST_RESP:      cmd.op = OP_RESP;
      default:      cmd.op = OP_NONE;
    endcase
  end

endmodule

[hdl/amc_datapath.sv]
module amc_datapath import amc_pkg::*; #(
  parameter int NODES     = NODES_DEF,
  parameter int ALPHABET  = ALPHABET_DEF,
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int PATTERNS  = PATTERNS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [1:0]       in_mode,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_end,
  input  logic [ID_W-1:0]  in_id,
  output logic             out_valid,
  input  logic             out_ready,
  output kind_t            out_kind,
  output logic [ID_W-1:0]  out_id,
  output logic [POS_W-1:0] out_start,
  output logic             out_last
);

  localparam int NW     = $clog2(NODES);
  localparam int SW     = $clog2(ALPHABET);
  localparam int DW     = $clog2(MAX_DEPTH + 1);
  localparam int CAW    = NW + SW;
  localparam int CDEPTH = NODES * (2 ** SW);
  localparam int LW     = 2 * NW;
  localparam int IW     = 1 + ID_W + DW;

  // Child table, link table {suffix, output}, node info {terminal, id, depth}, BFS queue
  logic           c_we;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [NW-1:0]  c_wdata, c_rdata;
  logic           l_we;
  logic [NW-1:0]  l_waddr, l_raddr;
  logic [LW-1:0]  l_wdata, l_rdata;
  logic           i_we;
  logic [NW-1:0]  i_waddr, i_raddr;
  logic [IW-1:0]  i_wdata, i_rdata;
  logic           q_we;
  logic [NW-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

  amc_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );
  amc_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );
  amc_ram #(.WIDTH(IW), .DEPTH(NODES)) u_info (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );
  amc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // Registers
  logic [CAW-1:0]   clr_cnt;
  mode_t            mode_r;
  logic [SYM_W-1:0] sym_r;
  logic             end_r;
  logic [ID_W-1:0]  id_r;
  logic [NW:0]      node_count;
  logic [NW-1:0]    insert_node, scan_node;
  logic [NW-1:0]    cur, u, f, c, t, v, ufs;
  logic [POS_W-1:0] pos;
  logic [NW:0]      head, tail;
  logic [SW-1:0]    a;
  logic [CNT_W-1:0] n;
  kind_t            resp_kind;

  // Decoded read data
  logic [NW-1:0]   l_suf, l_out;
  logic            i_term;
  logic [ID_W-1:0] i_pat;
  logic [DW-1:0]   i_depth;

  assign l_suf   = l_rdata[LW-1:NW];
  assign l_out   = l_rdata[NW-1:0];
  assign i_term  = i_rdata[IW-1];
  assign i_pat   = i_rdata[DW +: ID_W];
  assign i_depth = i_rdata[DW-1:0];

  // Decisions
  logic             sym_bad, id_ok, need_new, ins_fail, tag_ok, q_full, out_free;
  logic [NW-1:0]    nc, s_e, u_sel;
  logic [POS_W-1:0] depth_ext, start_pos;

  assign sym_bad  = {1'b0, sym_r} >= (SYM_W+1)'(ALPHABET);
  assign id_ok    = {5'd0, id_r} < 13'(PATTERNS);
  assign nc       = node_count[NW-1:0];
  assign need_new = (c_rdata == '0);
  assign ins_fail = sym_bad ||
                    (need_new && ((node_count == (NW+1)'(NODES)) ||
                                  (i_depth >= DW'(MAX_DEPTH))));
  assign tag_ok   = end_r && id_ok;
  assign q_full   = (tail == (NW+1)'(NODES));
  assign s_e      = sym_bad ? '0 : c_rdata;
  assign u_sel    = i_term ? v : l_out;
  assign out_free = !out_valid || out_ready;

  // Match start: pos - depth + 1, floored at 1
  assign depth_ext = POS_W'(i_depth);
  assign start_pos = (pos >= depth_ext) ? (pos - depth_ext + POS_W'(1)) : POS_W'(1);

  always_comb begin
    sts.clr_last  = (clr_cnt == CAW'(CDEPTH - 1));
    sts.mode      = mode_r;
    sts.ins_tag   = !ins_fail && !need_new && tag_ok;
    sts.a_last    = (a == SW'(ALPHABET - 1));
    sts.q_empty   = (head == tail);
    sts.c_zero    = (c_rdata == '0);
    sts.f_hit     = (c_rdata != '0) || (f == '0);
    sts.v_hit     = (s_e != '0) || (v == '0);
    sts.u_zero    = (u_sel == '0);
    sts.out_free  = out_free;
    sts.emit_last = (l_out == '0) || (n == CNT_W'(RESULT_CAP - 1));
  end

  // Memory addresses and writes
  always_comb begin
    c_we = 1'b0; c_waddr = {insert_node, sym_r[SW-1:0]}; c_wdata = nc;
    c_raddr = {v, sym_r[SW-1:0]};
    l_we = 1'b0; l_waddr = nc; l_wdata = '0; l_raddr = u;
    i_we = 1'b0; i_waddr = nc; i_wdata = '0; i_raddr = u;
    q_we = 1'b0; q_waddr = tail[NW-1:0]; q_wdata = c_rdata; q_raddr = head[NW-1:0];
    case (cmd.op)
      OP_CLEAR: begin
        c_we = 1'b1; c_waddr = clr_cnt; c_wdata = '0;
        l_we = 1'b1; l_waddr = '0;
        i_we = 1'b1; i_waddr = '0;
      end
      OP_INS_RD: begin
        c_raddr = {insert_node, sym_r[SW-1:0]};
        i_raddr = insert_node;
      end
      OP_INS_DEC: begin
        i_raddr = c_rdata;
        if (!ins_fail && need_new) begin
          c_we    = 1'b1;
          l_we    = 1'b1;
          i_we    = 1'b1;
          i_wdata = {tag_ok, tag_ok ? id_r : ID_W'(0), i_depth + DW'(1)};
        end
      end
      OP_INS_TAG: begin
        i_we    = 1'b1;
        i_waddr = cur;
        i_wdata = {1'b1, id_r, i_depth};
      end
      OP_BR_RD: c_raddr = {NW'(0), a};
      OP_BR_CHK: begin
        if (c_rdata != '0 && !q_full) begin
          l_we    = 1'b1;
          l_waddr = c_rdata;
          q_we    = 1'b1;
        end
      end
      OP_POP_WAIT: l_raddr = q_rdata;
      OP_C_RD:     c_raddr = {u, a};
      OP_F_RD:     c_raddr = {f, a};
      OP_F_CHK: begin
        if (sts.f_hit) begin
          l_raddr = c_rdata;
          i_raddr = c_rdata;
        end else begin
          l_raddr = f;
        end
      end
      OP_T_SET: begin
        l_we    = 1'b1;
        l_waddr = c;
        l_wdata = {t, i_term ? t : l_out};
        q_we    = !q_full;
        q_wdata = c;
      end
      OP_S_RD: c_raddr = {v, sym_r[SW-1:0]};
      OP_S_CHK: begin
        if (sts.v_hit) begin
          l_raddr = s_e;
          i_raddr = s_e;
        end else begin
          l_raddr = v;
        end
      end
      OP_S_U: begin
        l_raddr = u_sel;
        i_raddr = u_sel;
      end
      OP_EMIT: begin
        l_raddr = out_free ? l_out : u;
        i_raddr = out_free ? l_out : u;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      node_count  <= (NW+1)'(1);
      insert_node <= '0;
      scan_node   <= '0;
      pos         <= '0;
      head        <= '0;
      tail        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + CAW'(1);
        OP_INS_DEC: begin
          if (!ins_fail && need_new) begin
            node_count <= node_count + (NW+1)'(1);
          end
          if (end_r) begin
            insert_node <= '0;
          end else if (!ins_fail) begin
            insert_node <= need_new ? nc : c_rdata;
          end
        end
        OP_BLD_INIT: begin
          head <= '0;
          tail <= '0;
        end
        OP_BR_CHK: if (c_rdata != '0 && !q_full) tail <= tail + (NW+1)'(1);
        OP_POP:    if (!sts.q_empty) head <= head + (NW+1)'(1);
        OP_T_SET:  if (!q_full) tail <= tail + (NW+1)'(1);
        OP_BLD_DONE, OP_RESTART: begin
          scan_node <= '0;
          pos       <= '0;
        end
        OP_SCN_START: if (pos != '1) pos <= pos + POS_W'(1);
        OP_S_CHK:     if (sts.v_hit) scan_node <= s_e;
        OP_EMIT:      if (out_free) out_valid <= 1'b1;
        OP_RESP:      if (out_free) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        mode_r    <= mode_t'(in_mode);
        sym_r     <= in_symbol;
        end_r     <= in_end;
        id_r      <= in_id;
        resp_kind <= KIND_ACK;
      end
      OP_INS_DEC: begin
        cur       <= need_new ? nc : c_rdata;
        resp_kind <= (ins_fail || (end_r && !id_ok)) ? KIND_ERROR : KIND_ACK;
      end
      OP_BLD_INIT: a <= '0;
      OP_BR_CHK:   a <= a + SW'(1);
      OP_POP:      a <= '0;
      OP_POP_WAIT: u <= q_rdata;
      OP_U_LINK:   ufs <= l_suf;
      OP_C_CHK: begin
        c <= c_rdata;
        f <= ufs;
        if (c_rdata == '0) a <= a + SW'(1);
      end
      OP_F_CHK: if (sts.f_hit) t <= c_rdata;
      OP_F_SUF: f <= l_suf;
      OP_T_SET: a <= a + SW'(1);
      OP_SCN_START: begin
        v <= scan_node;
        n <= '0;
      end
      OP_S_CHK: if (sts.v_hit) v <= s_e;
      OP_S_SUF: v <= l_suf;
      OP_S_U: begin
        u <= u_sel;
        if (u_sel == '0) resp_kind <= KIND_NOMATCH;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_kind  <= KIND_MATCH;
          out_id    <= i_pat;
          out_start <= start_pos;
          out_last  <= sts.emit_last;
          u         <= l_out;
          n         <= n + CNT_W'(1);
        end
      end
      OP_RESP: begin
        if (out_free) begin
          out_kind  <= resp_kind;
          out_id    <= '0;
          out_start <= '0;
          out_last  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_node_count_range: assert property (@(posedge clk) disable iff (rst)
    node_count != '0 && node_count <= (NW+1)'(NODES))
    else $error("node count out of range");
  a_insert_node_live: assert property (@(posedge clk) disable iff (rst)
    {1'b0, insert_node} < node_count)
    else $error("insert pointer beyond allocated nodes");
  a_scan_node_live: assert property (@(posedge clk) disable iff (rst)
    cmd.op != OP_CLEAR |-> {1'b0, scan_node} < node_count)
    else $error("scan state beyond allocated nodes");
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("build queue head passed tail");
`endif

endmodule

[hdl/multi_pattern_string_matcher_unit.sv]
// Scan time grows with each failure hop and with each extra match.
// Build: the single child-table read port walks every symbol of every queued node, and
// each failure hop adds further child-table reads.
// One request in flight at a time; the output register lets the next request enter.
// Reset: synchronous; a clearing pass over all NODES * 2**clog2(ALPHABET) entries
// (65536 by default) zeroes the child table, no request accepted meanwhile.
module multi_pattern_string_matcher_unit import amc_pkg::*; #(
  parameter int NODES     = NODES_DEF,
  parameter int ALPHABET  = ALPHABET_DEF,
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int PATTERNS  = PATTERNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // symbol[7:0], pattern_id[15:8]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  input  logic        s_axis_tlast,   // pattern_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // match_id[7:0], start_position[39:8]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast    // last_result
);

  cmd_t             cmd;
  sts_t             sts;
  kind_t            out_kind;
  logic [ID_W-1:0]  out_id;
  logic [POS_W-1:0] out_start;

  amc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  amc_datapath #(
    .NODES     (NODES),
    .ALPHABET  (ALPHABET),
    .MAX_DEPTH (MAX_DEPTH),
    .PATTERNS  (PATTERNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (s_axis_tuser),
    .in_symbol (s_axis_tdata[7:0]),
    .in_end    (s_axis_tlast),
    .in_id     (s_axis_tdata[15:8]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (out_kind),
    .out_id    (out_id),
    .out_start (out_start),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_start, out_id};
  assign m_axis_tuser = out_kind;

endmodule
